FILE: src/lrn_across_channels_macros.svh
// Assertion helpers used by lrn_ctrl.sv.
`ifndef LRN_ACROSS_CHANNELS_MACROS_SVH
`define LRN_ACROSS_CHANNELS_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define LRN_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lrn assertion failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define LRN_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lrn assertion failed");

`endif

FILE: src/lrn_pkg.sv
package lrn_pkg;

    localparam int SUM_W      = 36;
    localparam int D_W        = 38;
    localparam int FRAC_W     = 20;
    localparam int MAX_OUT    = 8;
    localparam int MAX_WINDOW = 15;
    localparam int DLY_DEPTH  = 16;
    localparam int DLY_AW     = 4;

    localparam logic [1:0] CFG_WINDOW = 2'd0;
    localparam logic [1:0] CFG_ALPHA  = 2'd1;
    localparam logic [1:0] CFG_BETA   = 2'd2;
    localparam logic [1:0] CFG_BIAS   = 2'd3;

    localparam logic [3:0]  RST_WINDOW = 4'd5;
    localparam logic [31:0] RST_ALPHA  = 32'd429497;
    localparam logic [15:0] RST_BETA   = 16'd12288;
    localparam logic [15:0] RST_BIAS   = 16'd512;

    typedef struct packed {
        logic              load;
        logic              acc;
        logic              acc_sub;
        logic              fl_sub;
        logic              sq_re;
        logic              x_re;
        logic [DLY_AW-1:0] wr_addr;
        logic [DLY_AW-1:0] sq_addr;
        logic [DLY_AW-1:0] x_addr;
        logic              start;
        logic              push;
        logic              push_last;
        logic              clear;
    } t_cmd;

    typedef struct packed {
        logic norm_busy;
        logic out_free;
    } t_sts;

    typedef logic [29:0] t_rom [0:FRAC_W];

    function automatic logic [63:0] f_isqrt(input logic [63:0] v);
        logic [63:0] rem;
        logic [63:0] res;
        logic [63:0] bit_w;
        rem   = v;
        res   = '0;
        bit_w = 64'd1 << 62;
        for (int k = 0; k < 32; k++) begin
            if (bit_w != 0) begin
                if (bit_w <= rem || res != 0) begin
                    if (rem >= res + bit_w) begin
                        rem = rem - (res + bit_w);
                        res = (res >> 1) + bit_w;
                    end else begin
                        res = res >> 1;
                    end
                end
                bit_w = bit_w >> 2;
            end
        end
        return res;
    endfunction

    // Entry i approximates 2^(-2^-i) in Q0.30.
    function automatic t_rom f_build_rom();
        t_rom        rom;
        logic [63:0] prev;
        prev   = 64'd1 << 29;
        rom[0] = prev[29:0];
        for (int i = 1; i <= FRAC_W; i++) begin
            prev   = f_isqrt(prev << 30);
            rom[i] = prev[29:0];
        end
        return rom;
    endfunction

    localparam t_rom EXP_ROM = f_build_rom();

endpackage

FILE: src/lrn_ram.sv
module lrn_ram #(
    parameter int W = 16,
    parameter int D = 16
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic                 i_re,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [0:D-1];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/lrn_norm.sv
module lrn_norm #(
    parameter int SB = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [SB-1:0]             i_x,
    input  logic [lrn_pkg::SUM_W-1:0] i_sum,
    input  logic [31:0]               i_alpha,
    input  logic [15:0]               i_beta,
    input  logic [15:0]               i_bias,
    output logic                      o_busy,
    output logic [SB-1:0]             o_y
);

    localparam int MW = SB + 31;
    localparam logic [SB-1:0] POS_LIM = {1'b0, {(SB-1){1'b1}}};
    localparam logic [SB-1:0] NEG_LIM = {1'b1, {(SB-1){1'b0}}};

    typedef enum logic [8:0] {
        N_IDLE  = 9'b000000001,
        N_MUL   = 9'b000000010,
        N_SUMD  = 9'b000000100,
        N_NORM  = 9'b000001000,
        N_LOG   = 9'b000010000,
        N_POW   = 9'b000100000,
        N_EXP   = 9'b001000000,
        N_MAG   = 9'b010000000,
        N_SHIFT = 9'b100000000
    } t_nstate;

    t_nstate                   r_state;
    logic [SB-1:0]             r_x;
    logic                      r_neg;
    logic [SB-1:0]             r_ax;
    logic [lrn_pkg::SUM_W-1:0] r_sum;
    logic [63:0]               r_prod;
    logic [35:0]               r_hi;
    logic [lrn_pkg::D_W-1:0]   r_d;
    logic [5:0]                r_e;
    logic [30:0]               r_m;
    logic [19:0]               r_frac;
    logic [4:0]                r_cnt;
    logic signed [43:0]        r_p;
    logic [30:0]               r_g;
    logic [MW-1:0]             r_mag;
    logic [SB-1:0]             r_y;

    logic [61:0]        w_msq;
    logic [31:0]        w_t;
    logic [59:0]        w_gm;
    logic [19:0]        w_f;
    logic               w_fbit;
    logic signed [6:0]  w_es;
    logic signed [26:0] w_lq;
    logic signed [43:0] w_pw;
    logic signed [11:0] w_sh;
    logic signed [11:0] w_ns;
    logic [SB-1:0]      w_lim;
    logic [MW-1:0]      w_limw;
    logic [MW-1:0]      w_r;
    logic [SB-1:0]      w_rc;

    assign w_msq  = r_m * r_m;
    assign w_t    = w_msq[61:30];
    assign w_gm   = 60'(({29'd0, r_g} * {30'd0, lrn_pkg::EXP_ROM[r_cnt]}) >> 30);
    assign w_f    = r_p[33:14];
    assign w_fbit = w_f[5'(lrn_pkg::FRAC_W) - r_cnt];
    assign w_es   = $signed({1'b0, r_e}) - 7'sd16;
    assign w_lq   = {w_es, r_frac};
    assign w_pw   = $signed({1'b0, i_beta}) * w_lq;
    assign w_sh   = 12'sd30 + $signed({{2{r_p[43]}}, r_p[43:34]});
    assign w_ns   = 12'sd0 - w_sh;
    assign w_lim  = r_neg ? NEG_LIM : POS_LIM;
    assign w_limw = MW'(w_lim);

    // Scale back by 2^-(30+n), saturating on left shifts.
    always_comb begin
        if (w_sh >= 12'sd64) begin
            w_r = '0;
        end else if (!w_sh[11]) begin
            w_r = r_mag >> w_sh[5:0];
        end else if (r_mag == '0) begin
            w_r = '0;
        end else if (w_ns >= 12'sd63) begin
            w_r = w_limw;
        end else if (r_mag > (w_limw >> w_ns[5:0])) begin
            w_r = w_limw;
        end else begin
            w_r = r_mag << w_ns[5:0];
        end
        if (w_r > w_limw) begin
            w_rc = w_lim;
        end else begin
            w_rc = w_r[SB-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= N_IDLE;
        end else begin
            case (r_state)
                N_IDLE: begin
                    if (i_start) begin
                        r_x     <= i_x;
                        r_neg   <= i_x[SB-1];
                        r_ax    <= i_x[SB-1] ? (~i_x + 1'b1) : i_x;
                        r_sum   <= i_sum;
                        r_state <= N_MUL;
                    end
                end
                N_MUL: begin
                    r_prod  <= i_alpha * r_sum[31:0];
                    r_hi    <= {4'd0, i_alpha} * {32'd0, r_sum[35:32]};
                    r_state <= N_SUMD;
                end
                N_SUMD: begin
                    r_d     <= lrn_pkg::D_W'({i_bias, 8'd0}) + lrn_pkg::D_W'(r_hi)
                               + lrn_pkg::D_W'(r_prod[63:32]);
                    r_e     <= 6'(lrn_pkg::D_W - 1);
                    r_state <= N_NORM;
                end
                N_NORM: begin
                    if (r_d == '0) begin
                        if (i_beta == '0) begin
                            r_y <= r_x;
                        end else if (r_ax == '0) begin
                            r_y <= '0;
                        end else begin
                            r_y <= w_lim;
                        end
                        r_state <= N_IDLE;
                    end else if (r_d[lrn_pkg::D_W-1]) begin
                        r_m     <= r_d[lrn_pkg::D_W-1:7];
                        r_frac  <= '0;
                        r_cnt   <= '0;
                        r_state <= N_LOG;
                    end else begin
                        r_d <= r_d << 1;
                        r_e <= r_e - 1'b1;
                    end
                end
                N_LOG: begin
                    // One fraction bit per squaring.
                    if (w_t[31]) begin
                        r_m    <= w_t[31:1];
                        r_frac <= {r_frac[18:0], 1'b1};
                    end else begin
                        r_m    <= w_t[30:0];
                        r_frac <= {r_frac[18:0], 1'b0};
                    end
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 5'(lrn_pkg::FRAC_W - 1)) begin
                        r_state <= N_POW;
                    end
                end
                N_POW: begin
                    r_p     <= w_pw;
                    r_g     <= 31'd1 << 30;
                    r_cnt   <= 5'd1;
                    r_state <= N_EXP;
                end
                N_EXP: begin
                    if (w_fbit) begin
                        r_g <= w_gm[30:0];
                    end
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 5'(lrn_pkg::FRAC_W)) begin
                        r_state <= N_MAG;
                    end
                end
                N_MAG: begin
                    r_mag   <= {{(MW-SB){1'b0}}, r_ax} * {{(MW-31){1'b0}}, r_g};
                    r_state <= N_SHIFT;
                end
                N_SHIFT: begin
                    r_y     <= r_neg ? (~w_rc + 1'b1) : w_rc;
                    r_state <= N_IDLE;
                end
                default: begin
                    r_state <= N_IDLE;
                end
            endcase
        end
    end

    assign o_busy = (r_state != N_IDLE);
    assign o_y    = r_y;

endmodule

FILE: src/lrn_dp.sv
module lrn_dp #(
    parameter int SB = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lrn_pkg::t_cmd       i_cmd,
    input  logic [SB-1:0]       i_data,
    input  logic [31:0]         i_alpha,
    input  logic [15:0]         i_beta,
    input  logic [15:0]         i_bias,
    output lrn_pkg::t_sts       o_sts,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [SB-1:0]       o_y,
    output logic                o_last
);

    localparam int SW = lrn_pkg::SUM_W;

    logic [lrn_pkg::DLY_DEPTH-1:0] r_vld;
    logic                          r_sq_rv;
    logic                          r_x_rv;
    logic [SW-1:0]                 r_sum;
    logic [SW-1:0]                 r_sqx;
    logic                          r_ov;
    logic [SB-1:0]                 r_oy;
    logic                          r_ol;

    logic [SB-1:0]   w_ax;
    logic [2*SB-1:0] w_sq;
    logic [SW-1:0]   w_sq36;
    logic [SW-1:0]   w_sq_rd;
    logic [SB-1:0]   w_x_rd;
    logic [SW-1:0]   w_sq_m;
    logic [SB-1:0]   w_x_m;
    logic            w_busy;
    logic [SB-1:0]   w_ny;
    logic            w_free;

    assign w_ax   = i_data[SB-1] ? (~i_data + 1'b1) : i_data;
    assign w_sq   = w_ax * w_ax;
    assign w_sq36 = SW'(w_sq);

    lrn_ram #(.W(SB), .D(lrn_pkg::DLY_DEPTH)) u_x_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load),
        .i_waddr (i_cmd.wr_addr),
        .i_wdata (i_data),
        .i_re    (i_cmd.x_re),
        .i_raddr (i_cmd.x_addr),
        .o_rdata (w_x_rd)
    );

    lrn_ram #(.W(SW), .D(lrn_pkg::DLY_DEPTH)) u_sq_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load),
        .i_waddr (i_cmd.wr_addr),
        .i_wdata (w_sq36),
        .i_re    (i_cmd.sq_re),
        .i_raddr (i_cmd.sq_addr),
        .o_rdata (w_sq_rd)
    );

    // Entries never written since reset read as zero.
    assign w_sq_m = r_sq_rv ? w_sq_rd : '0;
    assign w_x_m  = r_x_rv ? w_x_rd : '0;

    lrn_norm #(.SB(SB)) u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.start),
        .i_x     (w_x_m),
        .i_sum   (r_sum),
        .i_alpha (i_alpha),
        .i_beta  (i_beta),
        .i_bias  (i_bias),
        .o_busy  (w_busy),
        .o_y     (w_ny)
    );

    assign w_free = !r_ov || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_sum <= '0;
            r_ov  <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_vld[i_cmd.wr_addr] <= 1'b1;
                r_sqx <= w_sq36;
            end
            if (i_cmd.sq_re) begin
                r_sq_rv <= r_vld[i_cmd.sq_addr];
            end
            if (i_cmd.x_re) begin
                r_x_rv <= r_vld[i_cmd.x_addr];
            end
            if (i_cmd.clear) begin
                r_sum <= '0;
            end else if (i_cmd.acc) begin
                r_sum <= r_sum + r_sqx - (i_cmd.acc_sub ? w_sq_m : '0);
            end else if (i_cmd.fl_sub) begin
                r_sum <= r_sum - w_sq_m;
            end
            if (i_cmd.push) begin
                r_ov <= 1'b1;
                r_oy <= w_ny;
                r_ol <= i_cmd.push_last;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_sts.norm_busy = w_busy;
    assign o_sts.out_free  = w_free;
    assign o_valid         = r_ov;
    assign o_y             = r_oy;
    assign o_last          = r_ol;

endmodule

FILE: src/lrn_ctrl.sv
`include "lrn_across_channels_macros.svh"

module lrn_ctrl #(
    parameter int MAX_CHANNELS = 256
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic          i_last,
    output logic          o_ready,
    input  logic [2:0]    i_h,
    input  lrn_pkg::t_sts i_sts,
    output lrn_pkg::t_cmd o_cmd
);

    localparam int CW = $clog2(MAX_CHANNELS + 1);
    localparam int XW = CW + 4;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_ACC    = 7'b0000010,
        S_START  = 7'b0000100,
        S_WAIT   = 7'b0001000,
        S_FL_CHK = 7'b0010000,
        S_FL_SUB = 7'b0100000,
        S_DONE   = 7'b1000000
    } t_state;

    t_state        r_state;
    t_state        n_state;
    logic [CW-1:0] r_c;
    logic [CW-1:0] r_em;
    logic [3:0]    r_nres;
    logic          r_last;

    lrn_pkg::t_cmd w_cmd;
    logic [XW-1:0] w_cx;
    logic [XW-1:0] w_ex;
    logic [XW-1:0] w_hx;
    logic [XW-1:0] w_old;
    logic [XW-1:0] w_fold;
    logic          w_more;

    assign w_cx   = XW'(r_c);
    assign w_ex   = XW'(r_em);
    assign w_hx   = XW'(i_h);
    assign w_old  = w_cx - (w_hx << 1) - 1'b1;
    assign w_fold = w_ex - w_hx - 1'b1;
    assign w_more = (w_ex + 1'b1 <= w_cx) && (r_nres + 1'b1 < 4'(lrn_pkg::MAX_OUT));

    always_comb begin
        w_cmd   = '0;
        n_state = r_state;
        o_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    w_cmd.load    = 1'b1;
                    w_cmd.wr_addr = w_cx[3:0];
                    w_cmd.sq_re   = 1'b1;
                    w_cmd.sq_addr = w_old[3:0];
                    n_state       = S_ACC;
                end
            end
            S_ACC: begin
                w_cmd.acc     = 1'b1;
                w_cmd.acc_sub = (w_cx >= (w_hx << 1) + 1'b1);
                w_cmd.x_re    = 1'b1;
                w_cmd.x_addr  = w_ex[3:0];
                if ((w_cx >= w_hx) && (w_ex + w_hx <= w_cx)) begin
                    n_state = S_START;
                end else if (r_last) begin
                    n_state = S_FL_CHK;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_START: begin
                w_cmd.start = 1'b1;
                n_state     = S_WAIT;
            end
            S_WAIT: begin
                if (!i_sts.norm_busy && i_sts.out_free) begin
                    w_cmd.push      = 1'b1;
                    w_cmd.push_last = r_last && !w_more;
                    n_state         = r_last ? S_FL_CHK : S_DONE;
                end
            end
            S_FL_CHK: begin
                if ((w_ex <= w_cx) && (r_nres < 4'(lrn_pkg::MAX_OUT))) begin
                    w_cmd.sq_re   = 1'b1;
                    w_cmd.sq_addr = w_fold[3:0];
                    n_state       = S_FL_SUB;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_FL_SUB: begin
                // Drop the channel that leaves the window at the bottom edge.
                w_cmd.fl_sub = (w_ex + w_hx > w_cx) && (w_ex >= w_hx + 1'b1);
                w_cmd.x_re   = 1'b1;
                w_cmd.x_addr = w_ex[3:0];
                n_state      = S_START;
            end
            S_DONE: begin
                w_cmd.clear = r_last;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_c     <= '0;
            r_em    <= '0;
            r_nres  <= '0;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_cmd.load) begin
                r_nres <= '0;
                r_last <= i_last || (w_cx + 1'b1 >= XW'(MAX_CHANNELS));
            end
            if (w_cmd.push) begin
                r_em   <= r_em + 1'b1;
                r_nres <= r_nres + 1'b1;
            end
            if (r_state == S_DONE) begin
                if (r_last) begin
                    r_c  <= '0;
                    r_em <= '0;
                end else begin
                    r_c <= r_c + 1'b1;
                end
            end
        end
    end

    assign o_cmd = w_cmd;

    `LRN_ASSERT_SAME(a_push_free, w_cmd.push, i_sts.out_free)
    `LRN_ASSERT_SAME(a_start_idle, w_cmd.start, !i_sts.norm_busy)
    `LRN_ASSERT_SAME(a_nres_cap, w_cmd.push, r_nres < 4'(lrn_pkg::MAX_OUT))
    `LRN_ASSERT_NEXT(a_accept_acc, (r_state == S_IDLE) && i_valid, r_state == S_ACC)

endmodule

FILE: src/lrn_across_channels.sv
// Result path: a request's own result reaches the output register after normalization
// (one-bit-a-cycle leading-one search, 20 log2 squarings, 20 exp2 products), which is cut
// short when the denominator is zero; output stalls delay it further.
// Requests: one request at a time; a new sample is taken only once the last one has released
// its result or none, and the last request of a pixel also flushes the remaining results.
// Reset: synchronous, active low; clears control, valid bits, window sum; loads defaults.
module lrn_across_channels #(
    parameter int SAMPLE_BITS  = 16,
    parameter int MAX_CHANNELS = 256
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0] i_s_tdata,   // sample
    input  logic                             i_s_tlast,   // last_channel
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0] o_m_tdata,   // normalized
    output logic                             o_m_tlast,   // last
    input  logic                             i_cfg_we,
    input  logic [1:0]                       i_cfg_idx,
    input  logic [31:0]                      i_cfg_wdata
);

    localparam int DW = ((SAMPLE_BITS + 7) / 8) * 8;

    logic [3:0]  r_ws;
    logic [31:0] r_alpha;
    logic [15:0] r_beta;
    logic [15:0] r_bias;

    logic [3:0]             w_wsc;
    logic [2:0]             w_h;
    lrn_pkg::t_cmd          w_cmd;
    lrn_pkg::t_sts          w_sts;
    logic [SAMPLE_BITS-1:0] w_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ws    <= lrn_pkg::RST_WINDOW;
            r_alpha <= lrn_pkg::RST_ALPHA;
            r_beta  <= lrn_pkg::RST_BETA;
            r_bias  <= lrn_pkg::RST_BIAS;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                lrn_pkg::CFG_WINDOW: r_ws    <= i_cfg_wdata[3:0];
                lrn_pkg::CFG_ALPHA:  r_alpha <= i_cfg_wdata;
                lrn_pkg::CFG_BETA:   r_beta  <= i_cfg_wdata[15:0];
                lrn_pkg::CFG_BIAS:   r_bias  <= i_cfg_wdata[15:0];
                default: begin
                end
            endcase
        end
    end

    assign w_wsc = (r_ws > 4'(lrn_pkg::MAX_WINDOW)) ? 4'(lrn_pkg::MAX_WINDOW) : r_ws;
    assign w_h   = w_wsc[3:1];

    lrn_ctrl #(.MAX_CHANNELS(MAX_CHANNELS)) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .i_last  (i_s_tlast),
        .o_ready (o_s_tready),
        .i_h     (w_h),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    lrn_dp #(.SB(SAMPLE_BITS)) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_data  (i_s_tdata[SAMPLE_BITS-1:0]),
        .i_alpha (r_alpha),
        .i_beta  (r_beta),
        .i_bias  (r_bias),
        .o_sts   (w_sts),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_y     (w_y),
        .o_last  (o_m_tlast)
    );

    assign o_m_tdata = DW'(w_y);

endmodule
